@@ hdl/spu_pkg.sv @@
package spu_pkg;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// coefficient and random fraction width
	localparam int COEF_W = 16;

	// register indexes of the configuration port
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_INERTIA_MIN     = 3'd0,
		REG_INERTIA_MAX     = 3'd1,
		REG_TOTAL_STEPS     = 3'd2,
		REG_ACCEL_PERSONAL  = 3'd3,
		REG_ACCEL_NEIGHBOUR = 3'd4,
		REG_BOUNDARY_MODE   = 3'd5
	} cfg_reg_t;

	// bound hit codes
	localparam int HIT_W = 2;
	typedef enum logic [HIT_W-1:0] {
		HIT_NONE  = 2'd0,
		HIT_LOWER = 2'd1,
		HIT_UPPER = 2'd2
	} hit_t;

	// register reset values
	localparam logic [COEF_W-1:0] RST_INERTIA_MIN = 16'd4915;
	localparam logic [COEF_W-1:0] RST_INERTIA_MAX = 16'd11957;
	localparam logic [COEF_W-1:0] RST_TOTAL_STEPS = 16'd500;
	localparam logic [COEF_W-1:0] RST_ACCEL       = 16'd24510;

endpackage

@@ hdl/spu_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// the dividend shifted right by QW must be below the divisor
module spu_div #(
	parameter int N  = 32,
	parameter int DW = 16,
	parameter int QW = 16,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [N-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	input  logic [PW-1:0] in_payload,
	output logic          out_valid,
	output logic [QW-1:0] quotient,
	output logic [DW-1:0] remainder,
	output logic [PW-1:0] out_payload
);

	logic          vld_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [N-1:0]  dd_s  [QW];
	logic [DW-1:0] dvs_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [PW-1:0] pl_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          v_i;
		logic [DW-1:0] r_i;
		logic [N-1:0]  d_i;
		logic [DW-1:0] dv_i;
		logic [QW-1:0] q_i;
		logic [PW-1:0] p_i;
		logic [DW:0]   trial;
		logic          fits;

		// stage input: port or previous stage
		if (k == 0) begin : g_first
			assign v_i  = in_valid;
			assign r_i  = DW'(dividend >> QW);
			assign d_i  = dividend << (N - QW);
			assign dv_i = divisor;
			assign q_i  = '0;
			assign p_i  = in_payload;
		end else begin : g_next
			assign v_i  = vld_s[k-1];
			assign r_i  = rem_s[k-1];
			assign d_i  = dd_s[k-1];
			assign dv_i = dvs_s[k-1];
			assign q_i  = quo_s[k-1];
			assign p_i  = pl_s[k-1];
		end

		// trial subtract of the divisor
		assign trial = {r_i, d_i[N-1]};
		assign fits  = trial >= {1'b0, dv_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fits ? DW'(trial - {1'b0, dv_i}) : DW'(trial);
				dd_s[k]  <= d_i << 1;
				dvs_s[k] <= dv_i;
				quo_s[k] <= {q_i[QW-2:0], fits};
				pl_s[k]  <= p_i;
			end
		end
	end

	assign out_valid   = vld_s[QW-1];
	assign quotient    = quo_s[QW-1];
	assign remainder   = rem_s[QW-1];
	assign out_payload = pl_s[QW-1];

endmodule

@@ hdl/swarm_particle_update.sv @@
// channel  | signals                       | content
// s_*      | s_tvalid s_tready s_tdata     | one coordinate of one particle
// m_*      | m_tvalid m_tready m_tdata     | updated coordinate, velocity, bound hit
// cfg_*    | cfg_we cfg_addr cfg_data      | schedule, coefficients, boundary mode
//
// one item per cycle while m_tready does not stall the output; the pipeline holds the
// 16 stage inertia divider and the COORD_WIDTH + 1 stage wrap divider
// arst_n clears the valid bits and loads the register reset values
// a stall on m_tready holds every stage at once and drops s_tready
// no item is lost or repeated
module swarm_particle_update #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// step_index, position, velocity, personal_best, neighbour_best,
	// rand_personal, rand_neighbour, lower_bound, upper_bound, zero fill
	input  logic [((6*COORD_WIDTH+48+7)/8)*8-1:0] s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// new_position, new_velocity, bound_hit, zero fill
	output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] m_tdata,
	input  logic                                cfg_we,
	input  logic [spu_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [spu_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW    = COORD_WIDTH;
	localparam int CWD   = spu_pkg::COEF_W;
	localparam int OUT_W = ((2*CW + 2 + 7) / 8) * 8;
	localparam int SW    = CW + 20;

	typedef struct packed {
		logic                 neg;
		logic                 use_min;
		logic                 use_max;
		logic signed [CW-1:0] pos;
		logic signed [CW-1:0] vel;
		logic signed [CW:0]   dp;
		logic signed [CW:0]   dn;
		logic [CWD-1:0]       rp;
		logic [CWD-1:0]       rn;
		logic signed [CW-1:0] lo;
		logic signed [CW-1:0] hi;
	} inr_pl_t;

	typedef struct packed {
		logic [spu_pkg::HIT_W-1:0] hit;
		logic                      wrap;
		logic signed [CW:0]        np;
		logic signed [CW-1:0]      lo;
		logic signed [CW-1:0]      hi;
		logic signed [CW-1:0]      nv;
	} bnd_pl_t;

	logic en;

	// configuration registers
	logic [CWD-1:0] inertia_min_q, inertia_max_q, total_steps_q;
	logic [CWD-1:0] accel_personal_q, accel_neighbour_q;
	logic           boundary_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_min_q     <= spu_pkg::RST_INERTIA_MIN;
			inertia_max_q     <= spu_pkg::RST_INERTIA_MAX;
			total_steps_q     <= spu_pkg::RST_TOTAL_STEPS;
			accel_personal_q  <= spu_pkg::RST_ACCEL;
			accel_neighbour_q <= spu_pkg::RST_ACCEL;
			boundary_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			case (spu_pkg::cfg_reg_t'(cfg_addr))
				spu_pkg::REG_INERTIA_MIN:     inertia_min_q     <= cfg_data;
				spu_pkg::REG_INERTIA_MAX:     inertia_max_q     <= cfg_data;
				spu_pkg::REG_TOTAL_STEPS:     total_steps_q     <= cfg_data;
				spu_pkg::REG_ACCEL_PERSONAL:  accel_personal_q  <= cfg_data;
				spu_pkg::REG_ACCEL_NEIGHBOUR: accel_neighbour_q <= cfg_data;
				spu_pkg::REG_BOUNDARY_MODE:   boundary_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: input register
	logic                 vld_s1;
	logic [CWD-1:0]       step_s1, r1_s1, r2_s1;
	logic signed [CW-1:0] pos_s1, vel_s1, pb_s1, nb_s1, lo_s1, hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= s_tdata[15:0];
			pos_s1  <= s_tdata[16 +: CW];
			vel_s1  <= s_tdata[16 + CW +: CW];
			pb_s1   <= s_tdata[16 + 2*CW +: CW];
			nb_s1   <= s_tdata[16 + 3*CW +: CW];
			r1_s1   <= s_tdata[16 + 4*CW +: 16];
			r2_s1   <= s_tdata[32 + 4*CW +: 16];
			lo_s1   <= s_tdata[48 + 4*CW +: CW];
			hi_s1   <= s_tdata[48 + 5*CW +: CW];
		end
	end

	// stage 2: schedule numerator, random coefficients, distances
	logic [CWD+1:0] d_full;
	logic [CWD-1:0] sched_d;
	logic           neg_c, use_min_c;
	logic [CWD-1:0] absdiff_c, dm_c;
	logic [2*CWD-1:0] rp_full, rn_full;

	assign d_full    = {2'b00, total_steps_q} + {1'b0, total_steps_q, 1'b0};
	assign sched_d   = d_full[CWD+1:2];
	assign neg_c     = inertia_max_q < inertia_min_q;
	assign use_min_c = step_s1 > sched_d;
	assign absdiff_c = neg_c ? inertia_min_q - inertia_max_q : inertia_max_q - inertia_min_q;
	assign dm_c      = sched_d - step_s1;
	assign rp_full   = accel_personal_q * r1_s1;
	assign rn_full   = accel_neighbour_q * r2_s1;

	logic             vld_s2;
	logic [2*CWD-1:0] num_s2;
	inr_pl_t          pl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2          <= absdiff_c * dm_c;
			pl_s2.neg       <= neg_c;
			pl_s2.use_min   <= use_min_c;
			pl_s2.use_max   <= (sched_d == '0) && !use_min_c;
			pl_s2.pos       <= pos_s1;
			pl_s2.vel       <= vel_s1;
			pl_s2.dp        <= {pb_s1[CW-1], pb_s1} - {pos_s1[CW-1], pos_s1};
			pl_s2.dn        <= {nb_s1[CW-1], nb_s1} - {pos_s1[CW-1], pos_s1};
			pl_s2.rp        <= rp_full[2*CWD-1:CWD];
			pl_s2.rn        <= rn_full[2*CWD-1:CWD];
			pl_s2.lo        <= lo_s1;
			pl_s2.hi        <= hi_s1;
		end
	end

	// inertia quotient, one bit per stage
	logic                 inr_vld;
	logic [CWD-1:0]       inr_q, inr_rem;
	logic [$bits(inr_pl_t)-1:0] inr_pl_vec;
	inr_pl_t              inr_pl;

	spu_div #(
		.N  (2*CWD),
		.DW (CWD),
		.QW (CWD),
		.PW ($bits(inr_pl_t))
	) u_inr_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (vld_s2),
		.dividend    (num_s2),
		.divisor     (sched_d),
		.in_payload  (pl_s2),
		.out_valid   (inr_vld),
		.quotient    (inr_q),
		.remainder   (inr_rem),
		.out_payload (inr_pl_vec)
	);

	assign inr_pl = inr_pl_t'(inr_pl_vec);

	// stage 3: inertia weight
	logic           vld_s3;
	logic [CWD-1:0] w_s3;
	inr_pl_t        pl_s3;
	logic [CWD-1:0] w_c;

	always_comb begin
		if (inr_pl.use_max) begin
			w_c = inertia_max_q;
		end else if (inr_pl.use_min) begin
			w_c = inertia_min_q;
		end else if (inr_pl.neg) begin
			w_c = inertia_min_q - inr_q;
		end else begin
			w_c = inertia_min_q + inr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= inr_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3  <= w_c;
			pl_s3 <= inr_pl;
		end
	end

	// stage 4: the three products
	logic                  vld_s4;
	logic signed [CW+16:0] pw_s4;
	logic signed [CW+17:0] pp_s4, pn_s4;
	logic signed [CW-1:0]  pos_s4, lo_s4, hi_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_s4  <= $signed({1'b0, w_s3}) * pl_s3.vel;
			pp_s4  <= $signed({1'b0, pl_s3.rp}) * pl_s3.dp;
			pn_s4  <= $signed({1'b0, pl_s3.rn}) * pl_s3.dn;
			pos_s4 <= pl_s3.pos;
			lo_s4  <= pl_s3.lo;
			hi_s4  <= pl_s3.hi;
		end
	end

	// stage 5: exact sum in Q.30
	logic                 vld_s5;
	logic signed [SW-1:0] sum_s5;
	logic signed [CW-1:0] pos_s5, lo_s5, hi_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= SW'(pw_s4) + SW'(pp_s4) + SW'(pn_s4);
			pos_s5 <= pos_s4;
			lo_s5  <= lo_s4;
			hi_s5  <= hi_s4;
		end
	end

	// stage 6: round half up to Q16.16 and saturate
	localparam logic signed [SW-1:0] SAT_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic signed [SW-1:0] ROUND_HALF = SW'(8192);

	logic signed [SW-1:0] rnd_c;
	logic signed [CW-1:0] nv_c;

	assign rnd_c = (sum_s5 + ROUND_HALF) >>> 14;

	always_comb begin
		if (rnd_c > SAT_MAX) begin
			nv_c = SAT_MAX[CW-1:0];
		end else if (rnd_c < SAT_MIN) begin
			nv_c = SAT_MIN[CW-1:0];
		end else begin
			nv_c = rnd_c[CW-1:0];
		end
	end

	logic                 vld_s6;
	logic signed [CW-1:0] nv_s6, pos_s6, lo_s6, hi_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nv_s6  <= nv_c;
			pos_s6 <= pos_s5;
			lo_s6  <= lo_s5;
			hi_s6  <= hi_s5;
		end
	end

	// stage 7: unbounded new position
	logic                 vld_s7;
	logic signed [CW:0]   np_s7;
	logic signed [CW-1:0] nv_s7, lo_s7, hi_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s7 <= {pos_s6[CW-1], pos_s6} + {nv_s6[CW-1], nv_s6};
			nv_s7 <= nv_s6;
			lo_s7 <= lo_s6;
			hi_s7 <= hi_s6;
		end
	end

	// bound tests and wrap operands
	logic signed [CW:0]   lo_x, hi_x;
	logic                 below_c, above_c;
	logic signed [CW+1:0] over_c;
	logic [CW:0]          span_c;
	bnd_pl_t              bnd_in;

	assign lo_x    = {lo_s7[CW-1], lo_s7};
	assign hi_x    = {hi_s7[CW-1], hi_s7};
	assign below_c = np_s7 < lo_x;
	assign above_c = np_s7 > hi_x;
	assign over_c  = below_c ? {lo_x[CW], lo_x} - {np_s7[CW], np_s7}
	                         : {np_s7[CW], np_s7} - {hi_x[CW], hi_x};
	assign span_c  = hi_x - lo_x;

	always_comb begin
		if (below_c) begin
			bnd_in.hit = spu_pkg::HIT_LOWER;
		end else if (above_c) begin
			bnd_in.hit = spu_pkg::HIT_UPPER;
		end else begin
			bnd_in.hit = spu_pkg::HIT_NONE;
		end
		bnd_in.wrap = boundary_mode_q && (hi_s7 > lo_s7);
		bnd_in.np   = np_s7;
		bnd_in.lo   = lo_s7;
		bnd_in.hi   = hi_s7;
		bnd_in.nv   = nv_s7;
	end

	// wrap remainder, one bit per stage
	logic                       bnd_vld;
	logic [CW:0]                bnd_q;
	logic [CW-1:0]              bnd_rem;
	logic [$bits(bnd_pl_t)-1:0] bnd_pl_vec;
	bnd_pl_t                    bnd_pl;

	spu_div #(
		.N  (CW + 1),
		.DW (CW),
		.QW (CW + 1),
		.PW ($bits(bnd_pl_t))
	) u_bnd_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (vld_s7),
		.dividend    (over_c[CW:0]),
		.divisor     (span_c[CW-1:0]),
		.in_payload  (bnd_in),
		.out_valid   (bnd_vld),
		.quotient    (bnd_q),
		.remainder   (bnd_rem),
		.out_payload (bnd_pl_vec)
	);

	assign bnd_pl = bnd_pl_t'(bnd_pl_vec);

	// final position and velocity
	logic signed [CW-1:0] np_c, nv_o;

	always_comb begin
		nv_o = '0;
		case (spu_pkg::hit_t'(bnd_pl.hit))
			spu_pkg::HIT_LOWER: begin
				np_c = bnd_pl.wrap ? bnd_pl.hi - $signed(bnd_rem) : bnd_pl.lo;
			end
			spu_pkg::HIT_UPPER: begin
				np_c = bnd_pl.wrap ? bnd_pl.lo + $signed(bnd_rem) : bnd_pl.hi;
			end
			default: begin
				np_c = bnd_pl.np[CW-1:0];
				nv_o = bnd_pl.nv;
			end
		endcase
	end

	// output register
	logic [OUT_W-1:0] out_data_q;
	logic             out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= bnd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= OUT_W'({bnd_pl.hit, nv_o, np_c});
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule
